// ----- rtl/core/cta_pkg.sv -----
// Package for the connection table with aging.
// Holds the item types, function codes, controller state and command/status structs.
// No dependencies; imported by every module of the block.
package cta_pkg;

   // Function codes of an input item.
   localparam logic FUNC_SEEN  = 1'b0;
   localparam logic FUNC_SWEEP = 1'b1;

   localparam int ADDR_W       = 48;
   localparam int TIME_W       = 32;
   localparam int SLOT_W       = 4;
   localparam int COUNT_OUT_W  = 5;
   localparam int RESULT_LIMIT = 16;
   localparam int REMOVED_W    = $clog2(RESULT_LIMIT + 1);

   localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd1000;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] now;
   } req_item_type;

   typedef struct packed {
      logic                   is_new;
      logic                   table_full;
      logic [SLOT_W-1:0]      slot;
      logic                   expired_valid;
      logic [ADDR_W-1:0]      expired_address;
      logic                   last;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CTA_IDLE,
      CTA_SEEN,
      CTA_SWEEP,
      CTA_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_seen;
      logic sweep_step;
      logic sweep_finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic out_free;
      logic expire;
      logic pend_valid;
      logic idx_last;
      logic removed_last;
   } status_type;

endpackage

// ----- rtl/core/cta_ctrl.sv -----
// Controller state machine of the connection table.
// Depends on cta_pkg for the state enum and the command/status structs.
module cta_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cta_pkg::status_type status,
   output cta_pkg::cmd_type    cmd
);
   import cta_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTA_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A sweep step may not run when it would push a held removal into a busy output.
   logic step_ok;
   assign step_ok = !(status.expire && status.pend_valid && !status.out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTA_IDLE: begin
            if (req_valid) begin
               state_in = (status.func == FUNC_SWEEP) ? CTA_SWEEP : CTA_SEEN;
            end
         end
         CTA_SEEN: begin
            if (status.out_free) begin
               state_in = CTA_IDLE;
            end
         end
         CTA_SWEEP: begin
            if (step_ok && (status.idx_last || (status.expire && status.removed_last))) begin
               state_in = CTA_FINISH;
            end
         end
         CTA_FINISH: begin
            if (status.out_free) begin
               state_in = CTA_IDLE;
            end
         end
         default: begin
            state_in = CTA_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTA_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         CTA_SEEN: begin
            cmd.do_seen = status.out_free;
         end
         CTA_SWEEP: begin
            cmd.sweep_step = step_ok;
         end
         CTA_FINISH: begin
            cmd.sweep_finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/core/cta_datapath.sv -----
// Datapath of the connection table: entry store, parallel lookup, sweep walker,
// held removal and output register. Depends on cta_pkg.
module cta_datapath #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cta_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cta_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   input  cta_pkg::cmd_type      cmd,
   output cta_pkg::status_type   status
);
   import cta_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic                entry_valid_ff     [TABLE_ENTRIES];
   logic [ADDR_W-1:0]   entry_address_ff   [TABLE_ENTRIES];
   logic [TIME_W-1:0]   entry_last_seen_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]    count_ff;
   logic [TIME_W-1:0]   expiry_ff;
   req_item_type        req_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [REMOVED_W-1:0] removed_ff;
   logic                pend_valid_ff;
   logic [IDX_W-1:0]    pend_slot_ff;
   logic [ADDR_W-1:0]   pend_addr_ff;
   logic [CNT_W-1:0]    pend_count_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        rsp_item_in;
   logic                rsp_load;

   // Parallel match and lowest free slot.
   logic             hit_any;
   logic [IDX_W-1:0] hit_idx;
   logic             free_any;
   logic [IDX_W-1:0] free_idx;

   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && (entry_address_ff[i] == req_ff.address)) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // Sweep evaluation of the entry under the walker.
   logic [TIME_W-1:0] age;
   logic              expire;
   assign age    = req_ff.now - entry_last_seen_ff[idx_ff];
   assign expire = entry_valid_ff[idx_ff] && (age > expiry_ff);

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.func         = req_item.func;
   assign status.out_free     = out_free;
   assign status.expire       = expire;
   assign status.pend_valid   = pend_valid_ff;
   assign status.idx_last     = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.removed_last = (removed_ff == REMOVED_W'(RESULT_LIMIT - 1));

   always_comb begin
      rsp_item_in = '0;
      rsp_load    = 1'b0;
      if (cmd.do_seen) begin
         rsp_load               = 1'b1;
         rsp_item_in.is_new     = !hit_any;
         rsp_item_in.table_full = !hit_any && !free_any;
         rsp_item_in.last       = 1'b1;
         if (hit_any) begin
            rsp_item_in.slot        = SLOT_W'(hit_idx);
            rsp_item_in.entry_count = COUNT_OUT_W'(count_ff);
         end else if (free_any) begin
            rsp_item_in.slot        = SLOT_W'(free_idx);
            rsp_item_in.entry_count = COUNT_OUT_W'(count_ff + CNT_W'(1));
         end else begin
            rsp_item_in.entry_count = COUNT_OUT_W'(count_ff);
         end
      end else if (cmd.sweep_step && expire && pend_valid_ff) begin
         rsp_load                    = 1'b1;
         rsp_item_in.slot            = SLOT_W'(pend_slot_ff);
         rsp_item_in.expired_valid   = 1'b1;
         rsp_item_in.expired_address = pend_addr_ff;
         rsp_item_in.entry_count     = COUNT_OUT_W'(pend_count_ff);
      end else if (cmd.sweep_finish) begin
         rsp_load         = 1'b1;
         rsp_item_in.last = 1'b1;
         if (pend_valid_ff) begin
            rsp_item_in.slot            = SLOT_W'(pend_slot_ff);
            rsp_item_in.expired_valid   = 1'b1;
            rsp_item_in.expired_address = pend_addr_ff;
            rsp_item_in.entry_count     = COUNT_OUT_W'(pend_count_ff);
         end else begin
            rsp_item_in.entry_count = COUNT_OUT_W'(count_ff);
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
         count_ff      <= '0;
         expiry_ff     <= EXPIRY_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            expiry_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.capture) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.do_seen && !hit_any && free_any) begin
            entry_valid_ff[free_idx] <= 1'b1;
            count_ff                 <= count_ff + CNT_W'(1);
         end
         if (cmd.sweep_step && expire) begin
            entry_valid_ff[idx_ff] <= 1'b0;
            count_ff               <= count_ff - CNT_W'(1);
            pend_valid_ff          <= 1'b1;
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff     <= req_item;
         idx_ff     <= '0;
         removed_ff <= '0;
      end
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
      if (cmd.do_seen) begin
         if (hit_any) begin
            entry_last_seen_ff[hit_idx] <= req_ff.now;
         end else if (free_any) begin
            entry_address_ff[free_idx]   <= req_ff.address;
            entry_last_seen_ff[free_idx] <= req_ff.now;
         end
      end
      if (cmd.sweep_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (expire) begin
            removed_ff    <= removed_ff + REMOVED_W'(1);
            pend_slot_ff  <= idx_ff;
            pend_addr_ff  <= entry_address_ff[idx_ff];
            pend_count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- rtl/core/connection_table_aging.sv -----
// Top level of the connection table with aging.
// Instantiates cta_ctrl and cta_datapath; types come from cta_pkg.
//
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | cta_pkg::req_item_type
// rsp     | out       | rsp_valid/rsp_stall | cta_pkg::rsp_item_type
// csr     | in        | csr_wr_en           | csr_wr_data (expiry_ticks)
//
// A seen item is accepted and registered in the idle state; the parallel match over
// all entries and the table update follow once the output is free and load it.
// In a sweep the walker visits one entry a cycle unless a held removal waits on a busy
// output, as the age subtract and compare unit is shared across the entries.
// Reset is synchronous and clears every valid bit, the count and the expiry setting
// to 1000 at once; no clearing pass follows.
// A stall on rsp holds the result in the output register; the block then waits
// before loading the next result, and req_stall stays high until the item is done.
module connection_table_aging #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cta_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cta_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);
   import cta_pkg::*;

   // The controller only sequences; all storage and arithmetic live in the datapath.
   cmd_type    cmd;
   status_type status;

   cta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds one removal back during a sweep so that the final one can
   // carry the last marker without looking ahead.
   cta_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ----- rtl/core/cta_checker.sv -----
// Port-level checker for the connection table, bound to its top level.
// Depends on cta_pkg for the result item type.
module cta_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input cta_pkg::rsp_item_type rsp_item
);
   import cta_pkg::*;

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item still in work");

   // Only removals of a sweep may be followed by further results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> rsp_item.expired_valid)
      else $error("non-final result that is not a removal");

   // A full table drop is a new address reported at slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.table_full |-> rsp_item.is_new && (rsp_item.slot == '0))
      else $error("table full result malformed");

   // Removals never carry lookup flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.expired_valid |-> !rsp_item.is_new && !rsp_item.table_full)
      else $error("removal carries lookup flags");

endmodule

bind connection_table_aging cta_checker u_cta_checker (.*);

// ----- test/connection_table_aging_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for connection_table_aging: directed and random seen/sweep items,
// expiry settings written between phases, results checked against a predicting scoreboard.
// Depends on cta_pkg and the connection_table_aging RTL only.

// The scoreboard keeps its own copy of the connection table and the expiry setting.
// Every accepted input item is turned into the results it must cause; every accepted
// result is compared field by field with the oldest of those.
class table_scoreboard;
   localparam int SLOTS = 16;

   logic [31:0]           expiry_ticks;
   bit                    slot_used  [SLOTS];
   logic [47:0]           slot_peer  [SLOTS];
   logic [31:0]           slot_stamp [SLOTS];
   int unsigned           live_entries;
   cta_pkg::rsp_item_type table_results_due[$];
   int unsigned           mismatch_count;

   function new();
      expiry_ticks   = cta_pkg::EXPIRY_RESET;
      live_entries   = 0;
      mismatch_count = 0;
      foreach (slot_used[i]) begin
         slot_used[i]  = 1'b0;
         slot_peer[i]  = '0;
         slot_stamp[i] = '0;
      end
   endfunction

   function void report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endfunction

   // Appends one expected result behind those already waiting.
   function void queue_result(input cta_pkg::rsp_item_type res);
      table_results_due.insert(table_results_due.size(), res);
   endfunction

   // Works out the lookup, insert or aging sweep for one accepted item.
   function void predict_from_request(input cta_pkg::req_item_type req);
      cta_pkg::rsp_item_type res;
      int                    free_slot;
      int                    hit_slot;
      int                    removed;
      logic [31:0]           age;
      res      = '0;
      res.last = 1'b1;
      if (req.func == cta_pkg::FUNC_SEEN) begin
         free_slot = -1;
         hit_slot  = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_peer[i] == req.address && hit_slot < 0)
               hit_slot = i;
            if (!slot_used[i] && free_slot < 0)
               free_slot = i;
         end
         if (hit_slot >= 0) begin
            slot_stamp[hit_slot] = req.now;
            res.slot             = 4'(hit_slot);
         end else if (free_slot < 0) begin
            // Table full: the address is dropped and nothing changes.
            res.is_new     = 1'b1;
            res.table_full = 1'b1;
         end else begin
            slot_used[free_slot]  = 1'b1;
            slot_peer[free_slot]  = req.address;
            slot_stamp[free_slot] = req.now;
            live_entries++;
            res.is_new = 1'b1;
            res.slot   = 4'(free_slot);
         end
         res.entry_count = 5'(live_entries);
         queue_result(res);
      end else begin
         removed = 0;
         for (int i = 0; i < SLOTS && removed < cta_pkg::RESULT_LIMIT; i++) begin
            age = req.now - slot_stamp[i];
            if (slot_used[i] && age > expiry_ticks) begin
               slot_used[i] = 1'b0;
               live_entries--;
               res                 = '0;
               res.slot            = 4'(i);
               res.expired_valid   = 1'b1;
               res.expired_address = slot_peer[i];
               res.entry_count     = 5'(live_entries);
               queue_result(res);
               removed++;
            end
         end
         if (removed == 0) begin
            // Nothing aged out: a single empty result closes the sweep.
            res.entry_count = 5'(live_entries);
            queue_result(res);
         end else begin
            table_results_due[table_results_due.size() - 1].last = 1'b1;
         end
      end
   endfunction

   function void check_response(input cta_pkg::rsp_item_type got);
      cta_pkg::rsp_item_type want;
      if (table_results_due.size() == 0) begin
         report_mismatch($sformatf("result %h arrived with nothing expected", got));
      end else begin
         want = table_results_due.pop_front();
         if (got.is_new !== want.is_new)
            report_mismatch($sformatf("is_new %b, expected %b", got.is_new, want.is_new));
         if (got.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, expected %b",
                                      got.table_full, want.table_full));
         if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
         if (got.expired_valid !== want.expired_valid)
            report_mismatch($sformatf("expired_valid %b, expected %b",
                                      got.expired_valid, want.expired_valid));
         if (got.expired_address !== want.expired_address)
            report_mismatch($sformatf("expired_address %h, expected %h",
                                      got.expired_address, want.expired_address));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
      end
   endfunction
endclass

module connection_table_aging_tb;
   import cta_pkg::*;

   localparam int TABLE_SIZE     = 16;
   // A sweep walks one entry a cycle while its output is free, so this covers the block finishing any item.
   localparam int SETTLE_CYCLES  = TABLE_SIZE + 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 40;
   localparam int POOL_SIZE      = 24;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en   = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   table_scoreboard tracker;

   // Idling percentages for the current phase, set by the stimulus process.
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   // The stimulus bumps the token to ask for a long receiver hold-off; the receiver
   // process notices the change and counts the hold-off down in its own cycles.
   int          hold_token     = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   // Running time base; it starts just short of the wrap so that ages wrap during the run.
   logic [31:0] tick_base      = 32'hFFFF_F000;
   logic [47:0] peer_pool [POOL_SIZE];

   connection_table_aging #(
      .TABLE_ENTRIES(TABLE_SIZE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Receiving side. Outputs are sampled straight after the rising edge, so they still
   // hold the values the block presented at that edge. The stall for the next edge is
   // chosen here too, either from the long hold-off or at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_item);
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: counts cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_item_type make_request(input logic func, input logic [47:0] address,
                                                 input logic [31:0] now);
      req_item_type it;
      it.func    = func;
      it.address = address;
      it.now     = now;
      return it;
   endfunction

   // Mostly lookups from a pool a little larger than the table, so that hits, inserts
   // and a full table all occur; a few addresses and times are pure noise.
   function automatic req_item_type random_request();
      req_item_type it;
      int           pick;
      tick_base  = tick_base + $urandom_range(60);
      pick       = $urandom_range(99);
      it.func    = FUNC_SEEN;
      it.address = peer_pool[$urandom_range(POOL_SIZE - 1)];
      it.now     = tick_base;
      if (pick < 12) begin
         it.func    = FUNC_SWEEP;
         it.address = {16'($urandom), $urandom};
      end else if (pick < 28) begin
         it.address = {16'($urandom), $urandom};
      end
      if ($urandom_range(99) < 4)
         it.now = $urandom;
      return it;
   endfunction

   // Offers one item and returns at the edge where it is taken. The valid is only
   // lowered when a gap is chosen, so it is never dropped and raised in one step.
   task automatic send_request(input req_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.predict_from_request(it);
   endtask

   // Stops offering and waits until every expected result has come back; with settle
   // set it then lets the block finish whatever sweep walk may still be running.
   task automatic wait_for_drain(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.table_results_due.size() != 0) @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_expiry(input logic [31:0] value);
      wait_for_drain(1'b1);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.expiry_ticks = value;
   endtask

   task automatic run_phase(input int phase, input int send_pct, input int recv_pct,
                            input logic [31:0] expiry);
      write_expiry(expiry);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // In the first phase the receiver holds off for a long stretch while items keep
         // coming, so the block fills up and stalls its input; in the second the sender
         // pauses once until the table has answered everything.
         if (phase == 0 && n == 10)
            hold_token <= hold_token + 1;
         if (phase == 1 && n == 20)
            wait_for_drain(1'b0);
         send_request(random_request());
      end
   endtask

   initial begin
      tracker = new();
      foreach (peer_pool[i])
         peer_pool[i] = {16'($urandom), $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset expiry of 1000 ticks. Extreme addresses and times
      // are inserted, then one of them is refreshed by a hit.
      send_request(make_request(FUNC_SEEN, 48'h0, 32'h0));
      send_request(make_request(FUNC_SEEN, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_request(FUNC_SEEN, 48'h0, 32'd5));
      // Ages of 5 and 11 ticks (the latter across the wrap): nothing expires.
      send_request(make_request(FUNC_SWEEP, 48'hFFFF_FFFF_FFFF, 32'd10));
      // Fill the remaining fourteen slots, then offer one more new address.
      for (int i = 0; i < 14; i++)
         send_request(make_request(FUNC_SEEN, 48'h5 << (3 * i), 32'd100));
      send_request(make_request(FUNC_SEEN, 48'hABCD_0123_4567, 32'd100));
      send_request(make_request(FUNC_SEEN, 48'hFFFF_FFFF_FFFF, 32'd2000));
      // Every entry has aged past the limit, one of them because its stamp lies in the
      // future and the age wraps, so all sixteen go in one sweep.
      send_request(make_request(FUNC_SWEEP, 48'h0, 32'd1500));

      // With an expiry of zero, an age of zero survives and an age of one does not.
      write_expiry(32'h0);
      send_request(make_request(FUNC_SEEN, 48'h1234_5678_9ABC, 32'd50));
      send_request(make_request(FUNC_SEEN, 48'h0F0F_F0F0_55AA, 32'd49));
      send_request(make_request(FUNC_SWEEP, 48'h0, 32'd50));
      // With the largest expiry even the longest possible age is kept.
      write_expiry(32'hFFFF_FFFF);
      send_request(make_request(FUNC_SWEEP, 48'h0, 32'd0));

      // Random part: no idling, sender idling, receiver stalling, then both.
      run_phase(0, 0, 0, $urandom_range(800, 200));
      run_phase(1, 50, 0, 32'hFFFF_FFFF);
      run_phase(2, 0, 50, $urandom_range(120, 20));
      run_phase(3, 33, 33, 32'h0);

      // Let any stray result show itself after the last expected one.
      wait_for_drain(1'b1);
      if (tracker.mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
